[src/msort_pkg.sv]
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types for the merge sorter: the sequencer states.
// ----------------------------------------------------------------------------
package msort_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_MERGE,
      ST_OUTPUT
   } state_type;

endpackage

[src/merge_sorter_core.sv]
// ----------------------------------------------------------------------------
// merge_sorter_core
// Stable ascending merge sort of up to MAX_ITEMS unsigned 32-bit keys.
// ----------------------------------------------------------------------------
// Usage:
//  - A request (req_value, req_last) is taken on a clock edge with start high
//    and busy low. Each request stores one key in buffer A.
//    Keys beyond MAX_ITEMS are discarded and remembered for the set.
//  - The request with req_last set raises busy and starts the sort: bottom-up
//    merge passes of run width 1, 2, 4, ... ping-ponging between buffers A
//    and B. ceil(log2 n) passes for n keys; each pass reads both run heads,
//    then compares and writes, for every key, plus one setup step per pair of
//    runs. The dual-read buffer RAM with its registered read is why the read
//    and the compare-and-write are separate steps.
//  - Results follow, one per cycle, on rsp_strobe, from the ST_OUTPUT state
//    through the registered buffer read; ST_OUTPUT follows the final merge
//    cycle (the cycle that took the key, for a one-key set). rsp_last_out
//    marks the final key; rsp_dropped is set on it if keys were discarded.
//    The receiver cannot stall: each result stands for exactly one cycle.
//  - busy falls once the final read has been issued, so the next set may start
//    loading while the final result is still on the rsp_ ports.
//  - reset clears the sequencer, the key count and the drop flag. Buffer
//    contents are not cleared: an entry's data is only used after this set wrote it.
// ----------------------------------------------------------------------------
module merge_sorter_core #(
   parameter int MAX_ITEMS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [31:0] rsp_sorted_value,
   output logic        rsp_last_out,
   output logic        rsp_dropped
);

   import msort_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int WID_W = CNT_W + 1;   // run width may reach twice the set
   localparam int SUM_W = CNT_W + 2;   // lo + 2*w
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;     // keys held
   logic             ovf_ff, ovf_in;         // a key was discarded
   logic             src_ff, src_in;         // 0: A is source, 1: B
   logic [WID_W-1:0] width_ff, width_in;     // run width of this pass
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] left_ff, left_in;       // i
   logic [CNT_W-1:0] right_ff, right_in;     // j
   logic [CNT_W-1:0] dst_ff, dst_in;         // k

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_drop_ff, rsp_drop_in;
   logic             rsp_src_ff, rsp_src_in;

   // Buffer ports
   logic             a_wr_en, b_wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;
   logic [IDX_W-1:0] rd_addr0, rd_addr1;
   logic [31:0]      a_rd0, a_rd1, b_rd0, b_rd1;

   // Load and merge helpers
   logic             accept;
   logic             has_room;
   logic [CNT_W-1:0] count_inc;
   logic [31:0]      head_left, head_right;
   logic             left_ok, right_ok, take_left;
   logic             run_done;
   logic [SUM_W-1:0] lo_next_wide;
   logic             pass_done;
   logic [WID_W-1:0] width_dbl;
   logic             sort_done;
   logic [SUM_W-1:0] mid_wide, hi_wide;
   logic             out_end;

   assign accept    = start && (state_ff == ST_IDLE);
   assign has_room  = count_ff < MAX_CNT;
   assign count_inc = has_room ? count_ff + 1'b1 : count_ff;

   assign head_left  = src_ff ? b_rd0 : a_rd0;
   assign head_right = src_ff ? b_rd1 : a_rd1;
   assign left_ok    = left_ff < mid_ff;
   assign right_ok   = right_ff < hi_ff;
   // Left run wins ties, which keeps the sort stable.
   assign take_left  = left_ok && (!right_ok || (head_left <= head_right));

   assign run_done     = (dst_ff + 1'b1) == hi_ff;
   assign lo_next_wide = SUM_W'(lo_ff) + (SUM_W'(width_ff) << 1);
   assign pass_done    = lo_next_wide >= SUM_W'(count_ff);
   assign width_dbl    = width_ff << 1;
   assign sort_done    = width_dbl >= WID_W'(count_ff);

   assign mid_wide = SUM_W'(lo_ff) + SUM_W'(width_ff);
   assign hi_wide  = SUM_W'(lo_ff) + (SUM_W'(width_ff) << 1);

   assign out_end = (dst_ff + 1'b1) == count_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               state_in = (count_inc < CNT_W'(2)) ? ST_OUTPUT : ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (!run_done) begin
               state_in = ST_READ;
            end else if (pass_done && sort_done) begin
               state_in = ST_OUTPUT;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_OUTPUT: begin
            if (out_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and buffer control
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      src_in       = src_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      dst_in       = dst_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_drop_in  = 1'b0;
      rsp_src_in   = src_ff;
      a_wr_en      = 1'b0;
      b_wr_en      = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = req_value;
      rd_addr0     = left_ff[IDX_W-1:0];
      rd_addr1     = right_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_wr_en  = has_room;
               count_in = count_inc;
               ovf_in   = ovf_ff || !has_room;
               if (req_last) begin
                  src_in   = 1'b0;
                  width_in = WID_W'(1);
                  lo_in    = '0;
                  dst_in   = '0;
               end
            end
         end
         ST_SETUP: begin
            mid_in   = (mid_wide > SUM_W'(count_ff)) ? count_ff : mid_wide[CNT_W-1:0];
            hi_in    = (hi_wide > SUM_W'(count_ff)) ? count_ff : hi_wide[CNT_W-1:0];
            left_in  = lo_ff;
            right_in = (mid_wide > SUM_W'(count_ff)) ? count_ff : mid_wide[CNT_W-1:0];
            dst_in   = lo_ff;
         end
         ST_READ: begin
            // heads of both runs are fetched here
         end
         ST_MERGE: begin
            a_wr_en = src_ff;
            b_wr_en = !src_ff;
            wr_addr = dst_ff[IDX_W-1:0];
            wr_data = take_left ? head_left : head_right;
            dst_in  = dst_ff + 1'b1;
            if (take_left) begin
               left_in = left_ff + 1'b1;
            end else begin
               right_in = right_ff + 1'b1;
            end
            if (run_done) begin
               if (pass_done) begin
                  width_in = width_dbl;
                  src_in   = !src_ff;
                  lo_in    = '0;
                  if (sort_done) begin
                     dst_in = '0;
                  end
               end else begin
                  lo_in = lo_next_wide[CNT_W-1:0];
               end
            end
         end
         ST_OUTPUT: begin
            rd_addr0     = dst_ff[IDX_W-1:0];
            rsp_valid_in = 1'b1;
            rsp_last_in  = out_end;
            rsp_drop_in  = out_end && ovf_ff;
            dst_in       = dst_ff + 1'b1;
            if (out_end) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      width_ff    <= width_in;
      lo_ff       <= lo_in;
      mid_ff      <= mid_in;
      hi_ff       <= hi_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      dst_ff      <= dst_in;
      rsp_last_ff <= rsp_last_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_src_ff  <= rsp_src_in;
   end

   msort_ram #(
      .WIDTH(32),
      .DEPTH(MAX_ITEMS)
   ) u_buf_a (
      .clock    (clock),
      .wr_en    (a_wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (a_rd0),
      .rd_data1 (a_rd1)
   );

   msort_ram #(
      .WIDTH(32),
      .DEPTH(MAX_ITEMS)
   ) u_buf_b (
      .clock    (clock),
      .wr_en    (b_wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (b_rd0),
      .rd_data1 (b_rd1)
   );

   assign busy             = state_ff != ST_IDLE;
   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_sorted_value = rsp_src_ff ? b_rd0 : a_rd0;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_dropped      = rsp_drop_ff;

endmodule

[src/msort_ram.sv]
// ----------------------------------------------------------------------------
// msort_ram
// Generic RAM: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module msort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem_ff[rd_addr0];
      rd_data1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule
